// ----- hw/rtl/lgr_pkg.sv -----
// Shared types and constants for the Laplace grid relaxation unit.
// Holds register indexes, command and status codes, FSM states and the
// control and status structs between controller and datapath.
`timescale 1ns / 1ps

package lgr_pkg;

  localparam int MAX_DIM    = 16;
  localparam int MAX_SWEEPS = 4096;
  localparam int DATA_W     = 32;
  localparam int SWEEP_W    = 16;
  localparam int DIM_CFG_W  = 5;
  localparam int TOL_W      = 31;
  localparam int IDX_W      = 4;
  localparam int APB_AW     = 5;
  localparam int APB_DW     = 32;

  localparam logic [DIM_CFG_W-1:0] DIM_RESET = DIM_CFG_W'(10);

  typedef enum logic [2:0] {
    REG_TOP    = 3'd0,
    REG_RIGHT  = 3'd1,
    REG_BOTTOM = 3'd2,
    REG_LEFT   = 3'd3,
    REG_ROWS   = 3'd4,
    REG_COLS   = 3'd5,
    REG_TOL    = 3'd6
  } reg_idx_e;

  typedef enum logic {
    CMD_SOLVE = 1'b0,
    CMD_READ  = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_CAP     = 2'd1,
    ST_RANGE   = 2'd2,
    ST_NOSOLVE = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    NB_NORTH,
    NB_SOUTH,
    NB_WEST,
    NB_EAST,
    NB_CENTER,
    NB_REQ
  } rd_sel_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_PREP,
    S_INIT,
    S_SWEEP,
    S_RD_N,
    S_RD_S,
    S_RD_W,
    S_RD_E,
    S_RD_C,
    S_WR,
    S_CMP,
    S_SWEEP_END,
    S_READ,
    S_DONE
  } state_e;

  typedef struct packed {
    logic [DATA_W-1:0]    top;
    logic [DATA_W-1:0]    right;
    logic [DATA_W-1:0]    bottom;
    logic [DATA_W-1:0]    left;
    logic [DIM_CFG_W-1:0] rows;
    logic [DIM_CFG_W-1:0] cols;
    logic [TOL_W-1:0]     tol;
  } cfg_t;

  typedef struct packed {
    logic    req_ld;
    logic    prep;
    logic    init_wr;
    logic    sweep_begin;
    logic    rd_en;
    rd_sel_e rd_sel;
    logic    acc_load;
    logic    acc_add;
    logic    cell_wr;
    logic    diff_ld;
    logic    cmp;
    logic    finish;
    logic    out_ld;
  } ctl_t;

  typedef struct packed {
    logic req_read;
    logic init_last;
    logic cell_last;
    logic converged;
    logic cap_reached;
  } sts_t;

endpackage

// ----- hw/rtl/laplace_grid_relaxation_unit.sv -----
// Top level of the Laplace grid relaxation unit: APB registers, controller,
// datapath and grid RAM. Depends on lgr_pkg, lgr_regs, lgr_ctrl,
// lgr_datapath and lgr_ram.
//
// One transaction at a time. A solve writes the whole R-by-C grid once, then
// sweeps its interior until it converges or reaches the sweep cap. The grid RAM
// has one read port, so each interior cell costs five reads, a write and a
// change compare. The next transaction is accepted while a finished result
// waits in the output register.
`timescale 1ns / 1ps

module laplace_grid_relaxation_unit #(
  parameter int MaxDim    = lgr_pkg::MAX_DIM,
  parameter int MaxSweeps = lgr_pkg::MAX_SWEEPS
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [lgr_pkg::APB_AW-1:0]         paddr,
  input  logic [lgr_pkg::APB_DW-1:0]         pwdata,
  output logic [lgr_pkg::APB_DW-1:0]         prdata,
  output logic                               pready,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic                               command_i,
  input  logic [lgr_pkg::IDX_W-1:0]          row_index_i,
  input  logic [lgr_pkg::IDX_W-1:0]          col_index_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic signed [lgr_pkg::DATA_W-1:0]  cell_value_o,
  output logic [lgr_pkg::SWEEP_W-1:0]        sweep_count_o,
  output logic [1:0]                         status_o
);

  import lgr_pkg::*;

  localparam int Depth = MaxDim * MaxDim;
  localparam int AddrW = $clog2(Depth);

  cfg_t              cfg;
  ctl_t              ctl;
  sts_t              sts;
  logic              ram_we, ram_re;
  logic [AddrW-1:0]  ram_waddr, ram_raddr;
  logic [DATA_W-1:0] ram_wdata, ram_rdata;

  lgr_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  lgr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .ctl_o       (ctl)
  );

  lgr_datapath #(
    .MaxDim    (MaxDim),
    .MaxSweeps (MaxSweeps)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg),
    .ctl_i         (ctl),
    .sts_o         (sts),
    .command_i     (command_i),
    .row_index_i   (row_index_i),
    .col_index_i   (col_index_i),
    .ram_we_o      (ram_we),
    .ram_waddr_o   (ram_waddr),
    .ram_wdata_o   (ram_wdata),
    .ram_re_o      (ram_re),
    .ram_raddr_o   (ram_raddr),
    .ram_rdata_i   (ram_rdata),
    .cell_value_o  (cell_value_o),
    .sweep_count_o (sweep_count_o),
    .status_o      (status_o)
  );

  lgr_ram #(
    .Width (DATA_W),
    .Depth (Depth)
  ) u_grid_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

`ifndef NO_ASSERTIONS
  a_ram_no_rw_overlap : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ram_we && ram_re))
    else $error("grid RAM read and write in the same cycle");

  a_one_in_flight : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("new transaction taken while one is in progress");

  a_error_value_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (status_o == ST_RANGE || status_o == ST_NOSOLVE))
      |-> (cell_value_o == '0))
    else $error("nonzero cell value on an error result");

  a_sweeps_capped : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (sweep_count_o <= SWEEP_W'(MaxSweeps)))
    else $error("sweep count above the cap");
`endif

endmodule

// ----- hw/rtl/lgr_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module lgr_ram #(
  parameter  int Width = 32,
  parameter  int Depth = 256,
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hw/rtl/lgr_regs.sv -----
// APB configuration registers: edge temperatures, grid size, tolerance.
// Depends on lgr_pkg.
`timescale 1ns / 1ps

module lgr_regs (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [lgr_pkg::APB_AW-1:0] paddr,
  input  logic [lgr_pkg::APB_DW-1:0] pwdata,
  output logic [lgr_pkg::APB_DW-1:0] prdata,
  output logic                      pready,
  output lgr_pkg::cfg_t             cfg_o
);

  import lgr_pkg::*;

  cfg_t     cfg_q, cfg_d;
  reg_idx_e idx;
  logic     wr_en;

  assign idx    = reg_idx_e'(paddr[APB_AW-1:2]);
  assign wr_en  = psel & penable & pwrite;
  assign pready = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (idx)
        REG_TOP:    cfg_d.top    = pwdata;
        REG_RIGHT:  cfg_d.right  = pwdata;
        REG_BOTTOM: cfg_d.bottom = pwdata;
        REG_LEFT:   cfg_d.left   = pwdata;
        REG_ROWS:   cfg_d.rows   = pwdata[DIM_CFG_W-1:0];
        REG_COLS:   cfg_d.cols   = pwdata[DIM_CFG_W-1:0];
        REG_TOL:    cfg_d.tol    = pwdata[TOL_W-1:0];
        default:    cfg_d        = cfg_q;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_TOP:    prdata = cfg_q.top;
      REG_RIGHT:  prdata = cfg_q.right;
      REG_BOTTOM: prdata = cfg_q.bottom;
      REG_LEFT:   prdata = cfg_q.left;
      REG_ROWS:   prdata = APB_DW'(cfg_q.rows);
      REG_COLS:   prdata = APB_DW'(cfg_q.cols);
      REG_TOL:    prdata = APB_DW'(cfg_q.tol);
      default:    prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.top    <= '0;
      cfg_q.right  <= '0;
      cfg_q.bottom <= '0;
      cfg_q.left   <= '0;
      cfg_q.rows   <= DIM_RESET;
      cfg_q.cols   <= DIM_RESET;
      cfg_q.tol    <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ----- hw/rtl/lgr_datapath.sv -----
// Datapath: cell counters, address generation, neighbor sum, change tracking,
// solve state and result register. Depends on lgr_pkg; drives the grid RAM.
`timescale 1ns / 1ps

module lgr_datapath #(
  parameter  int MaxDim    = lgr_pkg::MAX_DIM,
  parameter  int MaxSweeps = lgr_pkg::MAX_SWEEPS,
  localparam int AddrW     = $clog2(MaxDim * MaxDim)
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  lgr_pkg::cfg_t               cfg_i,
  input  lgr_pkg::ctl_t               ctl_i,
  output lgr_pkg::sts_t               sts_o,
  input  logic                        command_i,
  input  logic [lgr_pkg::IDX_W-1:0]   row_index_i,
  input  logic [lgr_pkg::IDX_W-1:0]   col_index_i,
  output logic                        ram_we_o,
  output logic [AddrW-1:0]            ram_waddr_o,
  output logic [lgr_pkg::DATA_W-1:0]  ram_wdata_o,
  output logic                        ram_re_o,
  output logic [AddrW-1:0]            ram_raddr_o,
  input  logic [lgr_pkg::DATA_W-1:0]  ram_rdata_i,
  output logic signed [lgr_pkg::DATA_W-1:0] cell_value_o,
  output logic [lgr_pkg::SWEEP_W-1:0] sweep_count_o,
  output logic [1:0]                  status_o
);

  import lgr_pkg::*;

  localparam int DW   = $clog2(MaxDim + 1);
  localparam int CmpW = (DW > IDX_W) ? DW : IDX_W;
  localparam int SumW = DATA_W + 2;
  localparam int DifW = DATA_W + 1;

  function automatic logic [AddrW-1:0] addr_of(input logic [DW-1:0] row,
                                               input logic [DW-1:0] col);
    return AddrW'(AddrW'(row) * AddrW'(MaxDim) + AddrW'(col));
  endfunction

  function automatic logic [DW-1:0] clamp_dim(input logic [DIM_CFG_W-1:0] d);
    logic [DW-1:0] res;
    if (d < DIM_CFG_W'(3)) begin
      res = DW'(3);
    end else if (int'(d) > MaxDim) begin
      res = DW'(MaxDim);
    end else begin
      res = DW'(d);
    end
    return res;
  endfunction

  // control state
  logic [DW-1:0]      nr_q, nc_q, r_q, c_q;
  logic [DW-1:0]      nr_d, nc_d, r_d, c_d;
  logic [SWEEP_W-1:0] sweeps_q, sweeps_d;
  logic [SWEEP_W-1:0] last_sweeps_q, last_sweeps_d;
  logic [DifW-1:0]    worst_q, worst_d;
  logic               solved_q, solved_d;
  logic               cap_q, cap_d;

  // payload
  logic                   req_cmd_q;
  logic [IDX_W-1:0]       req_row_q, req_col_q;
  logic [DATA_W-1:0]      start_q;
  logic signed [SumW-1:0] sum_q;
  logic signed [DifW-1:0] diff_q;
  logic [DATA_W-1:0]      out_value_q;
  logic [1:0]             out_status_q;
  logic [SWEEP_W-1:0]     out_sweeps_q;

  logic signed [SumW-1:0] edge_sum, rdata_ext;
  logic [DATA_W-1:0]      avg, init_val;
  logic signed [DifW-1:0] diff_d;
  logic [DifW-1:0]        abs_diff;
  logic [DW-1:0]          nr_m1, nc_m1, nr_m2, nc_m2, r_dec, r_inc, c_dec, c_inc;
  logic                   out_of_range;
  status_e                cap_status;

  assign nr_m1 = nr_q - DW'(1);
  assign nc_m1 = nc_q - DW'(1);
  assign nr_m2 = nr_q - DW'(2);
  assign nc_m2 = nc_q - DW'(2);
  assign r_dec = r_q - DW'(1);
  assign r_inc = r_q + DW'(1);
  assign c_dec = c_q - DW'(1);
  assign c_inc = c_q + DW'(1);

  assign edge_sum = {{2{cfg_i.top[DATA_W-1]}}, cfg_i.top}
                  + {{2{cfg_i.right[DATA_W-1]}}, cfg_i.right}
                  + {{2{cfg_i.bottom[DATA_W-1]}}, cfg_i.bottom}
                  + {{2{cfg_i.left[DATA_W-1]}}, cfg_i.left};

  assign rdata_ext = {{2{ram_rdata_i[DATA_W-1]}}, ram_rdata_i};
  assign avg       = sum_q[SumW-1:2];
  assign diff_d    = $signed({avg[DATA_W-1], avg}) - $signed({ram_rdata_i[DATA_W-1], ram_rdata_i});
  assign abs_diff  = diff_q[DifW-1] ? DifW'(-diff_q) : DifW'(diff_q);

  always_comb begin
    priority if (c_q == '0) begin
      init_val = cfg_i.left;
    end else if (r_q == nr_m1) begin
      init_val = cfg_i.bottom;
    end else if (c_q == nc_m1) begin
      init_val = cfg_i.right;
    end else if (r_q == '0) begin
      init_val = cfg_i.top;
    end else begin
      init_val = start_q;
    end
  end

  assign ram_we_o    = ctl_i.init_wr | ctl_i.cell_wr;
  assign ram_waddr_o = addr_of(r_q, c_q);
  assign ram_wdata_o = ctl_i.init_wr ? init_val : avg;
  assign ram_re_o    = ctl_i.rd_en;

  always_comb begin
    unique case (ctl_i.rd_sel)
      NB_NORTH:  ram_raddr_o = addr_of(r_dec, c_q);
      NB_SOUTH:  ram_raddr_o = addr_of(r_inc, c_q);
      NB_WEST:   ram_raddr_o = addr_of(r_q, c_dec);
      NB_EAST:   ram_raddr_o = addr_of(r_q, c_inc);
      NB_CENTER: ram_raddr_o = addr_of(r_q, c_q);
      NB_REQ:    ram_raddr_o = addr_of(DW'(req_row_q), DW'(req_col_q));
      default:   ram_raddr_o = addr_of(r_q, c_q);
    endcase
  end

  always_comb begin
    nr_d          = nr_q;
    nc_d          = nc_q;
    r_d           = r_q;
    c_d           = c_q;
    sweeps_d      = sweeps_q;
    last_sweeps_d = last_sweeps_q;
    worst_d       = worst_q;
    solved_d      = solved_q;
    cap_d         = cap_q;
    if (ctl_i.prep) begin
      nr_d     = clamp_dim(cfg_i.rows);
      nc_d     = clamp_dim(cfg_i.cols);
      r_d      = '0;
      c_d      = '0;
      sweeps_d = '0;
    end
    if (ctl_i.init_wr) begin
      if (c_q == nc_m1) begin
        c_d = '0;
        r_d = r_inc;
      end else begin
        c_d = c_inc;
      end
    end
    if (ctl_i.sweep_begin) begin
      r_d      = DW'(1);
      c_d      = DW'(1);
      sweeps_d = sweeps_q + SWEEP_W'(1);
      worst_d  = '0;
    end
    if (ctl_i.cmp) begin
      if (abs_diff > worst_q) begin
        worst_d = abs_diff;
      end
      if (c_q == nc_m2) begin
        c_d = DW'(1);
        r_d = r_inc;
      end else begin
        c_d = c_inc;
      end
    end
    if (ctl_i.finish) begin
      solved_d      = 1'b1;
      last_sweeps_d = sweeps_q;
      cap_d         = ~sts_o.converged;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nr_q          <= '0;
      nc_q          <= '0;
      r_q           <= '0;
      c_q           <= '0;
      sweeps_q      <= '0;
      last_sweeps_q <= '0;
      worst_q       <= '0;
      solved_q      <= 1'b0;
      cap_q         <= 1'b0;
    end else begin
      nr_q          <= nr_d;
      nc_q          <= nc_d;
      r_q           <= r_d;
      c_q           <= c_d;
      sweeps_q      <= sweeps_d;
      last_sweeps_q <= last_sweeps_d;
      worst_q       <= worst_d;
      solved_q      <= solved_d;
      cap_q         <= cap_d;
    end
  end

  assign out_of_range = (CmpW'(req_row_q) >= CmpW'(nr_q)) ||
                        (CmpW'(req_col_q) >= CmpW'(nc_q));
  assign cap_status   = cap_q ? ST_CAP : ST_OK;

  always_ff @(posedge clk_i) begin
    if (ctl_i.req_ld) begin
      req_cmd_q <= command_i;
      req_row_q <= row_index_i;
      req_col_q <= col_index_i;
    end
    if (ctl_i.prep) begin
      start_q <= edge_sum[SumW-1:2];
    end
    if (ctl_i.acc_load) begin
      sum_q <= rdata_ext;
    end else if (ctl_i.acc_add) begin
      sum_q <= sum_q + rdata_ext;
    end
    if (ctl_i.diff_ld) begin
      diff_q <= diff_d;
    end
    if (ctl_i.out_ld) begin
      out_sweeps_q <= last_sweeps_q;
      priority if (cmd_e'(req_cmd_q) == CMD_SOLVE) begin
        out_value_q  <= '0;
        out_status_q <= cap_status;
      end else if (!solved_q) begin
        out_value_q  <= '0;
        out_status_q <= ST_NOSOLVE;
      end else if (out_of_range) begin
        out_value_q  <= '0;
        out_status_q <= ST_RANGE;
      end else begin
        out_value_q  <= ram_rdata_i;
        out_status_q <= cap_status;
      end
    end
  end

  assign sts_o.req_read    = (cmd_e'(req_cmd_q) == CMD_READ);
  assign sts_o.init_last   = (r_q == nr_m1) && (c_q == nc_m1);
  assign sts_o.cell_last   = (r_q == nr_m2) && (c_q == nc_m2);
  assign sts_o.converged   = (worst_q <= DifW'(cfg_i.tol));
  assign sts_o.cap_reached = (sweeps_q == SWEEP_W'(MaxSweeps));

  assign cell_value_o  = out_value_q;
  assign sweep_count_o = out_sweeps_q;
  assign status_o      = out_status_q;

endmodule

// ----- hw/rtl/lgr_ctrl.sv -----
// Controller FSM: sequences grid init, Gauss-Seidel sweeps, cell reads and
// the result handshake. Depends on lgr_pkg; commands lgr_datapath.
`timescale 1ns / 1ps

module lgr_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  input  lgr_pkg::sts_t sts_i,
  output lgr_pkg::ctl_t ctl_o
);

  import lgr_pkg::*;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   slot_free;

  assign slot_free = ~out_valid_q | out_ready_i;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:      if (in_valid_i) state_d = S_DISPATCH;
      S_DISPATCH:  state_d = sts_i.req_read ? S_READ : S_PREP;
      S_PREP:      state_d = S_INIT;
      S_INIT:      if (sts_i.init_last) state_d = S_SWEEP;
      S_SWEEP:     state_d = S_RD_N;
      S_RD_N:      state_d = S_RD_S;
      S_RD_S:      state_d = S_RD_W;
      S_RD_W:      state_d = S_RD_E;
      S_RD_E:      state_d = S_RD_C;
      S_RD_C:      state_d = S_WR;
      S_WR:        state_d = S_CMP;
      S_CMP:       state_d = sts_i.cell_last ? S_SWEEP_END : S_RD_N;
      S_SWEEP_END: state_d = (sts_i.converged || sts_i.cap_reached) ? S_DONE : S_SWEEP;
      S_READ:      state_d = S_DONE;
      S_DONE:      if (slot_free) state_d = S_IDLE;
      default:     state_d = S_IDLE;
    endcase
  end

  always_comb begin
    ctl_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o   = 1'b1;
        ctl_o.req_ld = in_valid_i;
      end
      S_PREP:  ctl_o.prep        = 1'b1;
      S_INIT:  ctl_o.init_wr     = 1'b1;
      S_SWEEP: ctl_o.sweep_begin = 1'b1;
      S_RD_N: begin
        ctl_o.rd_en  = 1'b1;
        ctl_o.rd_sel = NB_NORTH;
      end
      S_RD_S: begin
        ctl_o.rd_en    = 1'b1;
        ctl_o.rd_sel   = NB_SOUTH;
        ctl_o.acc_load = 1'b1;
      end
      S_RD_W: begin
        ctl_o.rd_en   = 1'b1;
        ctl_o.rd_sel  = NB_WEST;
        ctl_o.acc_add = 1'b1;
      end
      S_RD_E: begin
        ctl_o.rd_en   = 1'b1;
        ctl_o.rd_sel  = NB_EAST;
        ctl_o.acc_add = 1'b1;
      end
      S_RD_C: begin
        ctl_o.rd_en   = 1'b1;
        ctl_o.rd_sel  = NB_CENTER;
        ctl_o.acc_add = 1'b1;
      end
      S_WR: begin
        ctl_o.cell_wr = 1'b1;
        ctl_o.diff_ld = 1'b1;
      end
      S_CMP:       ctl_o.cmp    = 1'b1;
      S_SWEEP_END: ctl_o.finish = sts_i.converged | sts_i.cap_reached;
      S_READ: begin
        ctl_o.rd_en  = 1'b1;
        ctl_o.rd_sel = NB_REQ;
      end
      S_DONE:  ctl_o.out_ld = slot_free;
      default: ctl_o = '0;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (ctl_o.out_ld) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule
